/* rtl/core/mwi_pkg.sv */
// Package for the Montgomery word inverse block.
// Holds the shared constants, the controller state type and the command/status structs.
// No dependencies.
package mwi_pkg;

  localparam int WORD_W      = 32;
  localparam int ROUND_LIMIT = 64;
  // Restoring divider handles a 33-bit dividend (2^32 on the first round)
  localparam int DIV_STEPS   = WORD_W + 1;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_UPD,
    ST_FINISH
  } mwi_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic mul;
    logic update;
    logic finish;
  } mwi_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic rem_zero;
    logic round_done;
    logic div_last;
  } mwi_status_t;

endpackage

/* rtl/core/mwi_datapath.sv */
// Datapath of the Montgomery word inverse block: Euclid registers, bit-serial divider,
// coefficient multiplier and result register.
// Depends on mwi_pkg.
module mwi_datapath #(
  parameter int ROUND_LIMIT = mwi_pkg::ROUND_LIMIT
) (
  input  logic                         clk,
  input  logic [mwi_pkg::WORD_W-1:0]   word_in,
  input  mwi_pkg::mwi_cmd_t            cmd,
  output mwi_pkg::mwi_status_t         status,
  output logic [mwi_pkg::WORD_W-1:0]   result
);

  localparam int W       = mwi_pkg::WORD_W;
  localparam int ROUND_W = $clog2(ROUND_LIMIT + 1);

  // Euclid state; dvd == 0 stands for 2^32 before the first round
  logic [W-1:0] rem;
  logic [W-1:0] dvd;
  logic [W-1:0] co_cur;
  logic [W-1:0] co_prev;
  logic [W-1:0] product;
  logic [ROUND_W-1:0] round_cnt;

  // Divider: quo starts as the dividend and shifts into the quotient
  logic [W:0] quo;
  logic [W:0] part;
  logic [mwi_pkg::DIV_CNT_W-1:0] bit_cnt;

  logic [W:0] shifted;
  logic       ge;

  // One restoring step
  always_comb begin
    shifted = {part[W-1:0], quo[W]};
    ge      = (shifted >= {1'b0, rem});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem       <= word_in;
      dvd       <= '0;
      co_cur    <= W'(1);
      co_prev   <= '0;
      round_cnt <= '0;
    end
    if (cmd.div_start) begin
      quo     <= (dvd == '0) ? {1'b1, {W{1'b0}}} : {1'b0, dvd};
      part    <= '0;
      bit_cnt <= '0;
    end
    if (cmd.div_step) begin
      part    <= ge ? (shifted - {1'b0, rem}) : shifted;
      quo     <= {quo[W-1:0], ge};
      bit_cnt <= bit_cnt + 1'b1;
    end
    // Quotient wraps to 32 bits, product wraps modulo 2^32
    if (cmd.mul) begin
      product <= W'(quo[W-1:0] * co_cur);
    end
    if (cmd.update) begin
      dvd       <= rem;
      rem       <= part[W-1:0];
      co_prev   <= co_cur;
      co_cur    <= co_prev - product;
      round_cnt <= round_cnt + 1'b1;
    end
    // gcd must be one, otherwise no inverse
    if (cmd.finish) begin
      result <= (dvd == W'(1)) ? (W'(0) - co_prev) : '0;
    end
  end

  always_comb begin
    status.rem_zero   = (rem == '0);
    status.round_done = (round_cnt == ROUND_W'(ROUND_LIMIT));
    status.div_last   = (bit_cnt == mwi_pkg::DIV_CNT_W'(mwi_pkg::DIV_STEPS - 1));
  end

endmodule

/* rtl/core/mwi_ctrl.sv */
// Controller of the Montgomery word inverse block: sequences rounds and owns the handshakes.
// Depends on mwi_pkg.
module mwi_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  mwi_pkg::mwi_status_t  status,
  output mwi_pkg::mwi_cmd_t     cmd
);

  mwi_pkg::mwi_state_t state;
  mwi_pkg::mwi_state_t state_next;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output request register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      mwi_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = mwi_pkg::ST_CHECK;
        end
      end
      mwi_pkg::ST_CHECK: begin
        if (status.rem_zero || status.round_done) begin
          state_next = mwi_pkg::ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = mwi_pkg::ST_DIV;
        end
      end
      mwi_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = mwi_pkg::ST_MUL;
        end
      end
      mwi_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = mwi_pkg::ST_UPD;
      end
      mwi_pkg::ST_UPD: begin
        cmd.update = 1'b1;
        state_next = mwi_pkg::ST_CHECK;
      end
      mwi_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = mwi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mwi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/montgomery_word_inverse.sv */
// Montgomery word inverse: returns -(w^-1) mod 2^32 for the low word of a modulus.
// Usage:
//   Slave channel s_* carries one request: the low 32-bit word of the modulus.
//   Master channel m_* returns one request: the Montgomery constant, or 0 when
//   the word is even or zero (no inverse modulo 2^32).
//   One request is processed at a time; s_tready is high only while idle.
// Timing:
//   Each Euclid round runs a check state, the one-bit-per-cycle restoring
//   divider over the 33-bit dividend, a multiply state and an update state.
//   The number of rounds is bounded by ROUND_LIMIT; the divider loop dominates.
//   A new request is accepted only after the previous result has been moved
//   to the output register.
// Reset: rst (synchronous, active high) returns the controller to idle and
//   drops m_tvalid; no other state is kept between requests.
// Stall: the result sits in an output register; while m_tready is low it stays
//   there, and the next finished result waits until that register is free.
// Depends on mwi_pkg, mwi_ctrl, mwi_datapath.
module montgomery_word_inverse #(
  parameter int ROUND_LIMIT = mwi_pkg::ROUND_LIMIT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [mwi_pkg::WORD_W-1:0]  s_tdata,   // [31:0] modulus_low_word
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [mwi_pkg::WORD_W-1:0]  m_tdata    // [31:0] montgomery_constant
);

  mwi_pkg::mwi_cmd_t    cmd;
  mwi_pkg::mwi_status_t status;

  // Sequencer
  mwi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Euclid datapath
  mwi_datapath #(
    .ROUND_LIMIT (ROUND_LIMIT)
  ) u_datapath (
    .clk     (clk),
    .word_in (s_tdata),
    .cmd     (cmd),
    .status  (status),
    .result  (m_tdata)
  );

`ifndef SYNTHESIS
  // A taken request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while busy");

  // A result appears only as the controller returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result raised outside idle");

  // The controller only issues one datapath command at a time
  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("overlapping datapath commands");
`endif

endmodule

/* bench/montgomery_word_inverse_test.sv */
// Self-checking bench for montgomery_word_inverse: Euclid-based predictor, scoreboard,
// directed table plus random modulus words under several handshake mixes.
// Depends on mwi_pkg and the montgomery_word_inverse RTL.
`timescale 1ns / 100ps

module montgomery_word_inverse_test;

  localparam int WORD_W       = mwi_pkg::WORD_W;
  localparam int ROUND_LIMIT  = mwi_pkg::ROUND_LIMIT;
  localparam int RANDOM_WORDS = 270;
  localparam int PHASE_LEN    = 45;
  localparam int HOLD_OFF_LEN = 3000;
  localparam int MAX_REPORTS  = 10;

  // One directed row; when known is set, constant is the hand-derived answer
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              known;
    logic [WORD_W-1:0] constant;
  } directed_row_t;

  // One outstanding request and the constant it should produce
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] constant;
  } pending_t;

  localparam int DIRECTED_ROWS = 20;
  directed_row_t directed_table [0:DIRECTED_ROWS-1] = '{
    '{32'h0000_0000, 1'b1, 32'h0000_0000},  // zero word: gcd stays 2^32
    '{32'h0000_0001, 1'b1, 32'hFFFF_FFFF},  // first quotient wraps to 0
    '{32'hFFFF_FFFF, 1'b1, 32'h0000_0001},  // -1 is its own inverse
    '{32'h0000_0002, 1'b1, 32'h0000_0000},  // even
    '{32'h8000_0000, 1'b1, 32'h0000_0000},  // top bit only, even
    '{32'hFFFF_FFFE, 1'b1, 32'h0000_0000},  // all ones but bit 0
    '{32'h4000_0000, 1'b1, 32'h0000_0000},
    '{32'h0000_0100, 1'b1, 32'h0000_0000},
    '{32'h0000_0003, 1'b1, 32'h5555_5555},
    '{32'hAAAA_AAAB, 1'b1, 32'hFFFF_FFFD},  // inverse of 3
    '{32'h8000_0001, 1'b1, 32'h7FFF_FFFF},  // self-inverse
    '{32'h0000_0005, 1'b0, 32'h0},
    '{32'h0000_0007, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 1'b0, 32'h0},
    '{32'hB119_24E1, 1'b0, 32'h0},          // Fibonacci 47
    '{32'h6D73_E55F, 1'b0, 32'h0},          // Fibonacci 46
    '{32'h0001_0001, 1'b0, 32'h0},
    '{32'h1234_5679, 1'b0, 32'h0},
    '{32'hDEAD_BEEF, 1'b0, 32'h0},
    '{32'hFFFF_FFFD, 1'b0, 32'h0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [WORD_W-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [WORD_W-1:0] m_tdata;

  pending_t    expected_constants [$];
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  logic        hold_off = 1'b0;
  int unsigned requests_accepted = 0;
  int unsigned results_checked   = 0;
  int unsigned odd_words         = 0;
  int unsigned failures          = 0;

  montgomery_word_inverse DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [31:0] modulus_low_word
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [31:0] montgomery_constant
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Extended Euclid on (2^32, word), tracking only the coefficient of word, mod 2^32
  function automatic logic [WORD_W-1:0] predict_constant(input logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] prev_rem;
    logic [WORD_W-1:0] cur_rem;
    logic [WORD_W-1:0] prev_coef;
    logic [WORD_W-1:0] cur_coef;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] next_rem;
    logic [WORD_W-1:0] next_coef;
    logic [WORD_W:0]   two_pow_w;
    int                rounds;
    prev_rem  = '0;   // zero here means 2^32
    cur_rem   = word;
    prev_coef = '0;
    cur_coef  = WORD_W'(1);
    two_pow_w = {1'b1, {WORD_W{1'b0}}};
    for (rounds = 0; rounds < ROUND_LIMIT; rounds++) begin
      if (cur_rem == 0) break;
      if (prev_rem == 0) begin
        quot = WORD_W'(two_pow_w / {1'b0, cur_rem});
      end else begin
        quot = prev_rem / cur_rem;
      end
      next_rem  = prev_rem - quot * cur_rem;
      next_coef = prev_coef - quot * cur_coef;
      prev_rem  = cur_rem;
      cur_rem   = next_rem;
      prev_coef = cur_coef;
      cur_coef  = next_coef;
    end
    return (prev_rem == 1) ? (WORD_W'(0) - prev_coef) : WORD_W'(0);
  endfunction

  // Random word mix: mostly odd words (full Euclid run), some even, edges, Fibonacci
  function automatic logic [WORD_W-1:0] random_modulus_word();
    logic [WORD_W-1:0] fib_a;
    logic [WORD_W-1:0] fib_b;
    logic [WORD_W-1:0] fib_t;
    int unsigned       pick;
    int unsigned       k;
    int unsigned       steps;
    pick = $urandom_range(99);
    if (pick < 60) return $urandom() | 32'h1;
    if (pick < 70) return $urandom() & ~32'h1;
    if (pick < 78) return WORD_W'($urandom_range(255)) | 32'h1;
    if (pick < 86) return 32'hFFFF_FFFF - WORD_W'($urandom_range(1023));
    if (pick < 92) begin
      fib_a = '0;
      fib_b = WORD_W'(1);
      steps = $urandom_range(47, 25);
      for (k = 0; k < steps; k++) begin
        fib_t = fib_a + fib_b;
        fib_a = fib_b;
        fib_b = fib_t;
      end
      return fib_a;
    end
    return (WORD_W'(1) << $urandom_range(31)) ^ WORD_W'($urandom_range(1));
  endfunction

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Present one request, with random idle cycles ahead of it, and log its expected result
  task automatic offer_word(input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] constant);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_constants.push_back('{word: word, constant: constant});
    requests_accepted++;
    if (word[0]) odd_words++;
  endtask

  // Output ready: random stalls per phase, forced low during the hold-off
  always @(posedge clk) begin
    if (hold_off) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Long output hold-off while requests keep coming, so the block backs up its input
  initial begin
    wait (requests_accepted == 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_LEN) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Scoreboard: compare each returned constant with the oldest outstanding request
  always @(posedge clk) begin : result_check
    pending_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (expected_constants.size() == 0) begin
        report_failure($sformatf("result 0x%08h with no request outstanding", m_tdata));
      end else begin
        want = expected_constants.pop_front();
        if (m_tdata !== want.constant) begin
          report_failure($sformatf("word 0x%08h: expected 0x%08h, got 0x%08h",
                                   want.word, want.constant, m_tdata));
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin
    int i;
    int unsigned drain;
    logic [WORD_W-1:0] word;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      word = directed_table[i].word;
      offer_word(word, directed_table[i].known ? directed_table[i].constant
                                               : predict_constant(word));
    end

    for (i = 0; i < RANDOM_WORDS; i++) begin
      // rotate: no idling, sender idle, receiver stall, both
      unique case ((i / PHASE_LEN) % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
        default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
      endcase
      word = random_modulus_word();
      offer_word(word, predict_constant(word));
    end
    s_tvalid <= 1'b0;

    drain = 0;
    while (expected_constants.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (50) @(posedge clk);

    if (expected_constants.size() != 0) begin
      report_failure($sformatf("%0d results never returned", expected_constants.size()));
    end
    $display("Covered %0d modulus words (%0d directed, %0d odd), %0d results checked,",
             requests_accepted, DIRECTED_ROWS, odd_words, results_checked);
    $display("under four idle/stall mixes and one %0d-cycle output hold-off; %0d failures.",
             HOLD_OFF_LEN, failures);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Timeout: block stopped making progress");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mwi_pkg.sv
rtl/core/mwi_datapath.sv
rtl/core/mwi_ctrl.sv
rtl/core/montgomery_word_inverse.sv
bench/montgomery_word_inverse_test.sv
